/* src/assert_macros.svh */
// assertion macros used by the rtl core
// needs nothing else; defining ASSERT_OFF turns every check into nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* src/itrt_pkg.sv */
// shared types and constants of the integer to radix text block
// no dependencies
package itrt_pkg;

    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int BASE_LEN_W = 5;
    localparam int SYM_BYTES  = 16;
    localparam int CHAR_W     = 8;
    localparam int APB_DW     = 64;
    localparam int APB_AW     = 5;
    localparam int REG_IDX_W  = 2;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    localparam logic [REG_IDX_W-1:0] REG_BASE_LEN     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_DIGIT
    } state_t;

endpackage

/* src/integer_to_radix_text_core.sv */
// integer to radix text converter, top level
// depends on itrt_pkg and assert_macros.svh
//
// Usage: the APB port sets base_len (0x00), symbols_low (0x08) and
// symbols_high (0x10); write them only while the block is idle.
// s_tdata carries one signed value per request. The block then emits its
// text on m_tdata, one character per request: a minus sign for negative
// values, then the digits most significant first, m_tlast on the final one.
// With an invalid alphabet a value is taken and produces no characters.
// Timing: one shared radix divider retires one quotient bit per cycle and
// finds all digits of a value before its first character; the characters
// then follow in order, each one held while m_tready is low.
// s_tready is high only when the block is idle, one value at a time.
// A stalled receiver simply holds the current character; the block waits.
// Reset (aresetn low, synchronous) clears the configuration registers to
// zero, which is an invalid alphabet, and returns the sequencer to idle.
`include "assert_macros.svh"

module integer_to_radix_text_core #(
    parameter int MAX_SYMBOLS = itrt_pkg::MAX_SYMBOLS_DEF,
    parameter int VALUE_WIDTH = itrt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]  s_tdata,   // value
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [itrt_pkg::CHAR_W-1:0]       m_tdata,   // out_char
    output logic                              m_tlast,   // last
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [itrt_pkg::APB_AW-1:0]       paddr,
    input  logic [itrt_pkg::APB_DW-1:0]       pwdata,
    output logic [itrt_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int BLW     = itrt_pkg::BASE_LEN_W;
    localparam int DIGIT_W = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int TRIAL_W = DIGIT_W + 1;
    localparam int IDX_W   = $clog2(VALUE_WIDTH);
    localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);
    localparam int SYMW    = itrt_pkg::SYM_BYTES * itrt_pkg::CHAR_W;

    // configuration registers
    logic [BLW-1:0]                   base_len_reg;
    logic [itrt_pkg::APB_DW-1:0]      symbols_low_reg;
    logic [itrt_pkg::APB_DW-1:0]      symbols_high_reg;

    // sequencer and datapath
    itrt_pkg::state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0]           mag_reg, mag_next;
    logic [DIGIT_W-1:0]               rem_reg, rem_next;
    logic [IDX_W-1:0]                 bit_reg, bit_next;
    logic [CNT_W-1:0]                 nd_reg, nd_next;
    logic                             neg_reg, neg_next;
    logic [DIGIT_W-1:0]               digits_reg [VALUE_WIDTH];

    logic                             cfg_write;
    logic [itrt_pkg::REG_IDX_W-1:0]   cfg_idx;
    logic                             alpha_ok;
    logic [SYMW-1:0]                  sym_table;
    logic [VALUE_WIDTH-1:0]           raw;
    logic [TRIAL_W-1:0]               trial;
    logic                             fits;
    logic [DIGIT_W-1:0]               rem_step;
    logic [VALUE_WIDTH-1:0]           mag_step;
    logic                             push_digit;
    logic [CNT_W-1:0]                 nd_dec;
    logic [DIGIT_W-1:0]               out_digit;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[itrt_pkg::APB_AW-1:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_len_reg     <= '0;
            symbols_low_reg  <= '0;
            symbols_high_reg <= '0;
        end else if (cfg_write) begin
            case (cfg_idx)
                itrt_pkg::REG_BASE_LEN:     base_len_reg     <= pwdata[BLW-1:0];
                itrt_pkg::REG_SYMBOLS_LOW:  symbols_low_reg  <= pwdata;
                itrt_pkg::REG_SYMBOLS_HIGH: symbols_high_reg <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            itrt_pkg::REG_BASE_LEN:     prdata = itrt_pkg::APB_DW'(base_len_reg);
            itrt_pkg::REG_SYMBOLS_LOW:  prdata = symbols_low_reg;
            itrt_pkg::REG_SYMBOLS_HIGH: prdata = symbols_high_reg;
            default:                    prdata = '0;
        endcase
    end

    // ---------------- alphabet check ----------------
    assign sym_table = {symbols_high_reg, symbols_low_reg};

    always_comb begin
        alpha_ok = (base_len_reg >= BLW'(2)) && (base_len_reg <= BLW'(MAX_SYMBOLS))
                   && (base_len_reg <= BLW'(itrt_pkg::SYM_BYTES));
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (BLW'(i) < base_len_reg) begin
                if (sym_table[i*8 +: 8] == itrt_pkg::CHAR_PLUS ||
                    sym_table[i*8 +: 8] == itrt_pkg::CHAR_MINUS) begin
                    alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
                    if (BLW'(j) < base_len_reg &&
                        sym_table[j*8 +: 8] == sym_table[i*8 +: 8]) begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // ---------------- shared divider step ----------------
    // restoring division by the radix, one quotient bit per cycle
    assign raw      = s_tdata[VALUE_WIDTH-1:0];
    assign trial    = {rem_reg, mag_reg[VALUE_WIDTH-1]};
    assign fits     = BLW'(trial) >= base_len_reg;
    assign rem_step = fits ? DIGIT_W'(BLW'(trial) - base_len_reg) : DIGIT_W'(trial);
    assign mag_step = {mag_reg[VALUE_WIDTH-2:0], fits};

    assign nd_dec    = nd_reg - 1'b1;
    assign out_digit = digits_reg[nd_dec[IDX_W-1:0]];

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= itrt_pkg::ST_IDLE;
            nd_reg    <= '0;
        end else begin
            state_reg <= state_next;
            nd_reg    <= nd_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        bit_reg <= bit_next;
        neg_reg <= neg_next;
        if (push_digit) begin
            digits_reg[nd_reg[IDX_W-1:0]] <= rem_step;
        end
    end

    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        nd_next    = nd_reg;
        neg_next   = neg_reg;
        push_digit = 1'b0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        m_tdata    = itrt_pkg::CHAR_MINUS;
        m_tlast    = 1'b0;
        case (state_reg)
            itrt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && alpha_ok) begin
                    neg_next   = raw[VALUE_WIDTH-1];
                    mag_next   = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
                    rem_next   = '0;
                    bit_next   = IDX_W'(VALUE_WIDTH - 1);
                    nd_next    = '0;
                    state_next = itrt_pkg::ST_DIVIDE;
                end
            end
            itrt_pkg::ST_DIVIDE: begin
                mag_next = mag_step;
                rem_next = rem_step;
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0) begin
                    // quotient and remainder complete: store digit, go again or emit
                    push_digit = 1'b1;
                    nd_next    = nd_reg + 1'b1;
                    rem_next   = '0;
                    bit_next   = IDX_W'(VALUE_WIDTH - 1);
                    if (mag_step == '0) begin
                        state_next = neg_reg ? itrt_pkg::ST_SIGN : itrt_pkg::ST_DIGIT;
                    end
                end
            end
            itrt_pkg::ST_SIGN: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = itrt_pkg::ST_DIGIT;
                end
            end
            itrt_pkg::ST_DIGIT: begin
                m_tvalid = 1'b1;
                m_tdata  = sym_table[4'(out_digit)*8 +: 8];
                m_tlast  = (nd_reg == CNT_W'(1));
                if (m_tready) begin
                    nd_next = nd_dec;
                    if (nd_reg == CNT_W'(1)) begin
                        state_next = itrt_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = itrt_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- checks ----------------
    `ASSERT_NEVER(a_no_overlap, aclk, aresetn, s_tready && m_tvalid)
    `ASSERT_AT(a_digit_pending, aclk, aresetn,
        state_reg == itrt_pkg::ST_DIGIT |-> nd_reg != '0)
    `ASSERT_AT(a_last_frees, aclk, aresetn, m_tvalid && m_tready && m_tlast |=> s_tready)
    `ASSERT_AT(a_bad_alpha_drop, aclk, aresetn, s_tvalid && s_tready && !alpha_ok |=> s_tready)

endmodule

/* verif/integer_to_radix_text_core_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for integer_to_radix_text_core: directed table, then random
// alphabets and values checked per character; depends on itrt_pkg and the core rtl
module integer_to_radix_text_core_test;

    localparam logic [itrt_pkg::REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    // drain wait covers the division of one value at radix 2 before its first character
    localparam int DRAIN_CYCLES   = 1 + itrt_pkg::VALUE_WIDTH_DEF * itrt_pkg::VALUE_WIDTH_DEF + 64;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int RANDOM_VALUES  = 248;

    typedef struct packed {
        logic [itrt_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } text_char_t;

    typedef enum logic {
        ROW_CFG,
        ROW_VALUE
    } row_kind_t;

    typedef struct {
        row_kind_t                            kind;
        logic [itrt_pkg::REG_IDX_W-1:0]       idx;
        logic [itrt_pkg::APB_DW-1:0]          data;
        logic [itrt_pkg::VALUE_WIDTH_DEF-1:0] value;
        bit                                   typed;
        string                                text;
    } stim_row_t;

    logic                                 aclk = 1'b0;
    logic                                 aresetn;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [itrt_pkg::VALUE_WIDTH_DEF-1:0] s_tdata;    // value
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [itrt_pkg::CHAR_W-1:0]          m_tdata;    // out_char
    logic                                 m_tlast;    // last
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [itrt_pkg::APB_AW-1:0]          paddr;
    logic [itrt_pkg::APB_DW-1:0]          pwdata;
    logic [itrt_pkg::APB_DW-1:0]          prdata;
    logic                                 pready;

    // shadow of the configuration registers
    logic [itrt_pkg::BASE_LEN_W-1:0] cfg_base_len;
    logic [63:0]                     cfg_sym_lo;
    logic [63:0]                     cfg_sym_hi;

    text_char_t pending_chars[$];
    stim_row_t  stim_rows[$];

    bit send_idle;
    bit recv_idle;
    bit need_drain;
    int err_cnt;
    int n_sent;
    int n_valid;
    int n_chars;
    int n_cfg;
    int stall_cycles;

    integer_to_radix_text_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("mismatch: %s", msg);
    endtask

    function automatic logic [itrt_pkg::CHAR_W-1:0] symbol_at(input int k);
        if (k < 8) begin
            return cfg_sym_lo[8*k +: 8];
        end
        return cfg_sym_hi[8*(k-8) +: 8];
    endfunction

    function automatic bit alphabet_valid();
        int n;
        n = cfg_base_len;
        if (n < 2 || n > itrt_pkg::MAX_SYMBOLS_DEF) begin
            return 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            if (symbol_at(i) == itrt_pkg::CHAR_PLUS || symbol_at(i) == itrt_pkg::CHAR_MINUS) begin
                return 1'b0;
            end
            for (int j = i + 1; j < n; j++) begin
                if (symbol_at(j) == symbol_at(i)) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // characters of one value: optional minus, then digits most significant first
    function automatic void predict_text(input logic [itrt_pkg::VALUE_WIDTH_DEF-1:0] v);
        logic [itrt_pkg::VALUE_WIDTH_DEF-1:0] mag;
        logic [itrt_pkg::VALUE_WIDTH_DEF-1:0] radix;
        int unsigned digs[$];
        if (!alphabet_valid()) begin
            return;
        end
        mag = v[itrt_pkg::VALUE_WIDTH_DEF-1] ? (~v + 1'b1) : v;
        radix = itrt_pkg::VALUE_WIDTH_DEF'(cfg_base_len);
        do begin
            digs.push_front(mag % radix);
            mag = mag / radix;
        end while (mag != 0);
        if (v[itrt_pkg::VALUE_WIDTH_DEF-1]) begin
            pending_chars.push_back(text_char_t'{ch: itrt_pkg::CHAR_MINUS, last: 1'b0});
        end
        foreach (digs[i]) begin
            pending_chars.push_back(text_char_t'{ch: symbol_at(digs[i]),
                                                 last: (i == digs.size() - 1)});
        end
    endfunction

    function automatic void add_cfg(input logic [itrt_pkg::REG_IDX_W-1:0] idx,
                                    input logic [itrt_pkg::APB_DW-1:0] d);
        stim_row_t r;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = d;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_val(input logic [itrt_pkg::VALUE_WIDTH_DEF-1:0] v,
                                    input bit typed, input string txt);
        stim_row_t r;
        r.kind  = ROW_VALUE;
        r.value = v;
        r.typed = typed;
        r.text  = txt;
        stim_rows.push_back(r);
    endfunction

    // hold off requests until every expected character has come back
    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_chars.size() != 0);
    endtask

    task automatic cfg_write(input logic [itrt_pkg::REG_IDX_W-1:0] idx,
                             input logic [itrt_pkg::APB_DW-1:0] d);
        if (need_drain) begin
            wait_results();
            // an invalid alphabet leaves no characters to wait for, so allow the full latency
            repeat (DRAIN_CYCLES) @(posedge aclk);
            need_drain = 1'b0;
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= d;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            itrt_pkg::REG_BASE_LEN:     cfg_base_len = d[itrt_pkg::BASE_LEN_W-1:0];
            itrt_pkg::REG_SYMBOLS_LOW:  cfg_sym_lo = d;
            itrt_pkg::REG_SYMBOLS_HIGH: cfg_sym_hi = d;
            default: ;
        endcase
        n_cfg++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_value(input logic [itrt_pkg::VALUE_WIDTH_DEF-1:0] v, input bit typed,
                              input string txt);
        int gap;
        gap = send_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        if (typed) begin
            for (int i = 0; i < txt.len(); i++) begin
                pending_chars.push_back(text_char_t'{ch: txt[i], last: (i == txt.len() - 1)});
            end
        end else begin
            predict_text(v);
        end
        if (alphabet_valid()) begin
            n_valid++;
        end
        n_sent++;
        need_drain = 1'b1;
    endtask

    task automatic pick_alphabet(input bit good, output logic [itrt_pkg::BASE_LEN_W-1:0] bl,
                                 output logic [63:0] lo, output logic [63:0] hi);
        logic [7:0] sym[16];
        logic [7:0] b;
        int j;
        int k;
        bit clash;
        bl = 5'($urandom_range(2, itrt_pkg::MAX_SYMBOLS_DEF));
        for (int i = 0; i < 16; i++) begin
            if (i < bl) begin
                do begin
                    b = 8'($urandom_range(0, 255));
                    clash = (b == itrt_pkg::CHAR_PLUS) || (b == itrt_pkg::CHAR_MINUS);
                    for (int m = 0; m < i; m++) begin
                        if (sym[m] == b) begin
                            clash = 1'b1;
                        end
                    end
                end while (clash);
                sym[i] = b;
            end else begin
                // unused slots may hold anything, a minus sign included
                sym[i] = ($urandom_range(0, 3) == 0) ? itrt_pkg::CHAR_MINUS
                                                     : 8'($urandom_range(0, 255));
            end
        end
        if (!good) begin
            case ($urandom_range(0, 3))
                0: bl = 5'($urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31));
                1: begin
                    j = $urandom_range(1, bl - 1);
                    k = $urandom_range(0, j - 1);
                    sym[j] = sym[k];
                end
                2: sym[$urandom_range(0, bl - 1)] = itrt_pkg::CHAR_PLUS;
                default: sym[$urandom_range(0, bl - 1)] = itrt_pkg::CHAR_MINUS;
            endcase
        end
        for (int i = 0; i < 8; i++) begin
            lo[8*i +: 8] = sym[i];
            hi[8*i +: 8] = sym[i+8];
        end
    endtask

    function automatic logic [itrt_pkg::VALUE_WIDTH_DEF-1:0] pick_value(input int radix);
        logic [63:0] p;
        logic [itrt_pkg::VALUE_WIDTH_DEF-1:0] v;
        int k;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom();
            3: v = $urandom_range(0, 40);
            4: v = -$urandom_range(1, 40);
            5: case ($urandom_range(0, 3))
                0: v = 32'h0000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'h8000_0000;
                default: v = 32'hFFFF_FFFF;
            endcase
            6, 7: begin
                // near a power of the radix, where the digit count changes
                p = 64'd1;
                k = $urandom_range(1, 31);
                if (radix >= 2) begin
                    repeat (k) begin
                        if (p * radix <= 64'h8000_0000) begin
                            p = p * radix;
                        end
                    end
                end
                v = p[31:0] + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1)) begin
                    v = -v;
                end
            end
            default: begin
                v = $urandom() >> $urandom_range(0, 31);
                if ($urandom_range(0, 1)) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    // receiver: random stall per character, each character checked in order
    initial begin
        int stall;
        text_char_t want;
        m_tready = 1'b0;
        forever begin
            stall = recv_idle ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid === 1'b1 && m_tready));
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character %02h last %b", m_tdata, m_tlast));
            end else begin
                want = pending_chars.pop_front();
                if (m_tdata !== want.ch) begin
                    report_mismatch($sformatf("character %02h, expected %02h", m_tdata, want.ch));
                end
                if (m_tlast !== want.last) begin
                    report_mismatch($sformatf("last %b, expected %b on character %02h",
                                              m_tlast, want.last, want.ch));
                end
                n_chars++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) ||
            (psel && penable && pready === 1'b1)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", stall_cycles);
            $display("integer_to_radix_text_core test failed");
            $finish;
        end
    end

    initial begin
        logic [itrt_pkg::BASE_LEN_W-1:0] bl;
        logic [63:0] cfg_val[3];
        logic [itrt_pkg::REG_IDX_W-1:0] idx;
        bit good;
        int first;
        int n_rand;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b1;
        paddr    = '0;
        pwdata   = '0;
        cfg_base_len = '0;
        cfg_sym_lo   = '0;
        cfg_sym_hi   = '0;
        send_idle    = 1'b1;
        recv_idle    = 1'b1;
        need_drain   = 1'b0;
        err_cnt      = 0;
        n_sent       = 0;
        n_valid      = 0;
        n_chars      = 0;
        n_cfg        = 0;
        stall_cycles = 0;
        n_rand       = 0;

        // registers out of reset: empty alphabet, values are taken silently
        add_val(32'h0000_0000, 1, "");
        add_val(32'hFFFF_FFFF, 1, "");
        // decimal
        add_cfg(itrt_pkg::REG_BASE_LEN, 64'd10);
        add_cfg(itrt_pkg::REG_SYMBOLS_LOW, 64'h3736_3534_3332_3130);
        add_cfg(itrt_pkg::REG_SYMBOLS_HIGH, 64'h0000_0000_0000_3938);
        add_val(32'h0000_0000, 1, "0");
        add_val(32'h7FFF_FFFF, 1, "2147483647");
        add_val(32'h8000_0000, 1, "-2147483648");
        add_val(-32'd7, 1, "-7");
        // write to an unmapped index must leave the alphabet alone
        add_cfg(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
        add_val(32'd12345, 1, "12345");
        // hexadecimal
        add_cfg(itrt_pkg::REG_BASE_LEN, 64'd16);
        add_cfg(itrt_pkg::REG_SYMBOLS_HIGH, 64'h6665_6463_6261_3938);
        add_val(32'hFFFF_FFFF, 1, "-1");
        add_val(32'h7FFF_FFFF, 1, "7fffffff");
        add_val(32'h8000_0000, 1, "-80000000");
        add_val(32'h1234_ABCD, 0, "");
        // binary with a zero byte symbol; unused low slots hold minus signs
        add_cfg(itrt_pkg::REG_BASE_LEN, 64'd2);
        add_cfg(itrt_pkg::REG_SYMBOLS_LOW, 64'h2D2D_2D2D_2D2D_FF00);
        add_val(32'h8000_0000, 0, "");
        add_val(32'h7FFF_FFFF, 0, "");
        add_val(32'h0000_0000, 0, "");
        add_val(32'd5, 0, "");
        // base_len keeps its low 5 bits only: 3, so the minus sign is now in use
        add_cfg(itrt_pkg::REG_BASE_LEN, 64'hFFFF_FFFF_FFFF_FFE3);
        add_val(32'd9, 1, "");
        // plus sign in use
        add_cfg(itrt_pkg::REG_SYMBOLS_LOW, 64'h0000_0000_002B_3130);
        add_val(32'd9, 1, "");
        // repeated symbol
        add_cfg(itrt_pkg::REG_SYMBOLS_LOW, 64'h0000_0000_0031_3130);
        add_val(32'd9, 1, "");
        // radix beyond the symbol count, then below two
        add_cfg(itrt_pkg::REG_SYMBOLS_LOW, 64'h0000_0000_0032_3130);
        add_cfg(itrt_pkg::REG_BASE_LEN, 64'd17);
        add_val(32'd9, 1, "");
        add_cfg(itrt_pkg::REG_BASE_LEN, 64'd1);
        add_val(32'd9, 1, "");
        // ternary
        add_cfg(itrt_pkg::REG_BASE_LEN, 64'd3);
        add_val(-32'd5, 1, "-12");
        add_val(32'd0, 1, "0");
        add_val(32'd8, 1, "22");

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[r]) begin
            if (stim_rows[r].kind == ROW_CFG) begin
                cfg_write(stim_rows[r].idx, stim_rows[r].data);
            end else begin
                send_value(stim_rows[r].value, stim_rows[r].typed, stim_rows[r].text);
            end
        end

        // random phases: new alphabet each time, mostly valid
        while (n_rand < RANDOM_VALUES) begin
            good = ($urandom_range(0, 4) != 0);
            pick_alphabet(good, bl, cfg_val[1], cfg_val[2]);
            cfg_val[0] = {$urandom(), $urandom()};
            cfg_val[0][itrt_pkg::BASE_LEN_W-1:0] = bl;
            first = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++) begin
                idx = itrt_pkg::REG_IDX_W'((first + i) % 3);
                cfg_write(idx, cfg_val[idx]);
            end
            if ($urandom_range(0, 5) == 0) begin
                cfg_write(REG_UNMAPPED, {$urandom(), $urandom()});
            end
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(5, 25)) begin
                if ($urandom_range(0, 24) == 0) begin
                    wait_results();
                end
                send_value(pick_value(int'(cfg_base_len)), 0, "");
                n_rand++;
            end
        end

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d values (%0d with a usable alphabet) across %0d register writes",
                 n_sent, n_valid, n_cfg);
        $display("checked %0d characters, %0d mismatches", n_chars, err_cnt);
        if (err_cnt == 0) begin
            $display("integer_to_radix_text_core test passed");
        end else begin
            $display("integer_to_radix_text_core test failed");
        end
        $finish;
    end

endmodule
